@@ design/sti_pkg.sv @@
package sti_pkg;

   localparam int KEY_W   = 32;
   localparam int DATA_W  = 32;
   localparam int INDEX_W = 6;
   localparam int POS_W   = 7;

   localparam logic [1:0] REQ_APPEND = 2'd0;
   localparam logic [1:0] REQ_INSERT = 2'd1;
   localparam logic [1:0] REQ_READ   = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   typedef struct packed {
      logic                     append;
      logic                     insert;
      logic                     read;
      logic signed [KEY_W-1:0]  key;
      logic [DATA_W-1:0]        payload;
      logic [INDEX_W-1:0]       read_index;
   } cmd_type;

   typedef struct packed {
      logic gt;
      logic place;
      logic hit;
   } cell_flags_type;

endpackage

@@ design/sti_if.sv @@
interface sti_req_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  req_type;
   logic signed [31:0]          key;
   logic [31:0]                 payload;
   logic [5:0]                  read_index;

   modport source (output valid, req_type, key, payload, read_index, input ready);
   modport sink   (input valid, req_type, key, payload, read_index, output ready);
endinterface

interface sti_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  status;
   logic [6:0]                  position;
   logic [6:0]                  entry_count;
   logic signed [31:0]          out_key;
   logic [31:0]                 out_payload;

   modport source (output valid, status, position, entry_count, out_key, out_payload,
                   input ready);
   modport sink   (input valid, status, position, entry_count, out_key, out_payload,
                   output ready);
endinterface

@@ design/sti_cell.sv @@
module sti_cell #(
   parameter int IDX   = 0,
   parameter int CNT_W = 7
) (
   input  logic                            clock,
   input  sti_pkg::cmd_type                cmd,
   input  logic [CNT_W-1:0]                count,
   input  logic                            gt_left,
   input  logic signed [sti_pkg::KEY_W-1:0] left_key,
   input  logic [sti_pkg::DATA_W-1:0]      left_payload,
   output logic signed [sti_pkg::KEY_W-1:0] key_ff,
   output logic [sti_pkg::DATA_W-1:0]      payload_ff,
   output sti_pkg::cell_flags_type         flags
);
   import sti_pkg::*;

   logic signed [KEY_W-1:0] key_in;
   logic [DATA_W-1:0]       payload_in;
   logic                    occupied;
   logic                    at_end;
   logic                    shift;

   assign occupied = CNT_W'(IDX) < count;
   assign at_end   = CNT_W'(IDX) == count;

   always_comb begin
      flags.gt    = occupied && (cmd.key < key_ff);
      flags.place = (cmd.append && at_end) ||
                    (cmd.insert && !gt_left && (flags.gt || at_end));
      flags.hit   = cmd.read && ((IDX >> INDEX_W) == 0) &&
                    (INDEX_W'(IDX) == cmd.read_index);
      shift       = cmd.insert && gt_left && (occupied || at_end);
   end

   always_comb begin
      key_in     = key_ff;
      payload_in = payload_ff;
      if (flags.place) begin
         key_in     = cmd.key;
         payload_in = cmd.payload;
      end else if (shift) begin
         key_in     = left_key;
         payload_in = left_payload;
      end
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      payload_ff <= payload_in;
   end

endmodule

@@ design/sorted_table_insert.sv @@
// Sorted record table, ascending by signed key.
// The request channel carries one word per request: append at the end,
// sorted insert (after any equal keys, later entries move up one place),
// or read of the entry at read_index. The response channel returns one
// word per request with status, position, entry count after the request
// and, for a good read, the stored key and payload.
// Every entry sits in its own cell; on an insert all cells compare the new
// key at once and each either keeps its record, takes its left neighbor's,
// or takes the new one. The response is registered and valid in the cycle
// after the request is accepted, and one request is accepted per cycle
// while the response side keeps up.
// A response waits in the output register; while the receiver stalls,
// the request side is held off once that register is full.
// Reset empties the table and the output register; stored records are not
// cleared, since entries at or above the count are never read.
// A full table rejects append and insert with status full.
module sorted_table_insert #(
   parameter int CAPACITY = 64
) (
   input  logic    clock,
   input  logic    reset,
   sti_req_if.sink   req,
   sti_rsp_if.source rsp
);
   import sti_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

   logic [CNT_W-1:0]        count_ff;
   logic [CNT_W-1:0]        count_in;
   logic                    rsp_valid_ff;
   logic [1:0]              status_ff;
   logic [1:0]              status_in;
   logic [POS_W-1:0]        position_ff;
   logic [POS_W-1:0]        position_in;
   logic [POS_W-1:0]        entry_count_ff;
   logic signed [KEY_W-1:0] out_key_ff;
   logic signed [KEY_W-1:0] out_key_in;
   logic [DATA_W-1:0]       out_payload_ff;
   logic [DATA_W-1:0]       out_payload_in;

   logic                    accept;
   logic                    full;
   logic                    in_range;
   cmd_type                 cmd;

   logic signed [KEY_W-1:0] cell_key [CAPACITY];
   logic [DATA_W-1:0]       cell_payload [CAPACITY];
   cell_flags_type          cell_flags [CAPACITY];
   logic [CAPACITY-1:0]     place_vec;
   logic [CAPACITY-1:0]     gt_vec;
   logic [CAPACITY-1:0]     gt_seen;
   logic [POS_W-1:0]        place_pos;
   logic signed [KEY_W-1:0] read_key;
   logic [DATA_W-1:0]       read_payload;

   assign req.ready = !reset && (!rsp_valid_ff || rsp.ready);
   assign accept    = req.valid && req.ready;
   assign full      = count_ff == CNT_W'(CAPACITY);
   assign in_range  = CMP_W'(req.read_index) < CMP_W'(count_ff);

   always_comb begin
      cmd.append     = accept && !full && (req.req_type == REQ_APPEND);
      cmd.insert     = accept && !full && (req.req_type == REQ_INSERT);
      cmd.read       = accept && (req.req_type == REQ_READ);
      cmd.key        = req.key;
      cmd.payload    = req.payload;
      cmd.read_index = req.read_index;
   end

   always_comb begin
      gt_seen = gt_vec;
      for (int s = 1; s < CAPACITY; s = s * 2) begin
         gt_seen = gt_seen | (gt_seen << s);
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_head
         sti_cell #(.IDX(i), .CNT_W(CNT_W)) u_cell (
            .clock        (clock),
            .cmd          (cmd),
            .count        (count_ff),
            .gt_left      (1'b0),
            .left_key     (cell_key[i]),
            .left_payload (cell_payload[i]),
            .key_ff       (cell_key[i]),
            .payload_ff   (cell_payload[i]),
            .flags        (cell_flags[i])
         );
      end else begin : g_body
         sti_cell #(.IDX(i), .CNT_W(CNT_W)) u_cell (
            .clock        (clock),
            .cmd          (cmd),
            .count        (count_ff),
            .gt_left      (gt_seen[i-1]),
            .left_key     (cell_key[i-1]),
            .left_payload (cell_payload[i-1]),
            .key_ff       (cell_key[i]),
            .payload_ff   (cell_payload[i]),
            .flags        (cell_flags[i])
         );
      end
      assign place_vec[i] = cell_flags[i].place;
      assign gt_vec[i]    = cell_flags[i].gt;
   end

   always_comb begin
      place_pos    = '0;
      read_key     = '0;
      read_payload = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (cell_flags[i].place) begin
            place_pos = place_pos | POS_W'(i);
         end
         if (cell_flags[i].hit) begin
            read_key     = read_key | cell_key[i];
            read_payload = read_payload | cell_payload[i];
         end
      end
   end

   always_comb begin
      count_in       = count_ff;
      status_in      = ST_OK;
      position_in    = '0;
      out_key_in     = '0;
      out_payload_in = '0;
      unique case (req.req_type)
         REQ_APPEND, REQ_INSERT: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               position_in = place_pos;
               count_in    = count_ff + CNT_W'(1);
            end
         end
         REQ_READ: begin
            position_in = POS_W'(req.read_index);
            if (in_range) begin
               out_key_in     = read_key;
               out_payload_in = read_payload;
            end else begin
               status_in = ST_RANGE;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff      <= status_in;
         position_ff    <= position_in;
         entry_count_ff <= POS_W'(count_in);
         out_key_ff     <= out_key_in;
         out_payload_ff <= out_payload_in;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = status_ff;
   assign rsp.position    = position_ff;
   assign rsp.entry_count = entry_count_ff;
   assign rsp.out_key     = out_key_ff;
   assign rsp.out_payload = out_payload_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("count above capacity");

   a_single_place: assert property (@(posedge clock) disable iff (reset)
      $onehot0(place_vec))
      else $error("more than one cell takes the new record");

   a_place_on_write: assert property (@(posedge clock) disable iff (reset)
      (cmd.append || cmd.insert) |-> $onehot(place_vec))
      else $error("accepted write stored in no cell");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (accept && (req.req_type == REQ_READ)) |=> $stable(count_ff))
      else $error("read changed the count");

endmodule
